FILE: hdl/ile_pkg.sv
package ile_pkg;

	localparam int CAPACITY   = 16;
	localparam int DATA_WIDTH = 32;

	localparam int FUNC_W   = 2;
	localparam int POS_W    = 5;
	localparam int DIN_W    = 32;
	localparam int DOUT_W   = 32;
	localparam int STATUS_W = 2;
	localparam int COUNT_W  = 5;

	// Entry count runs 0 .. CAPACITY; comparisons use the wider of count and position.
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int IDX_W = $clog2(CAPACITY);
	localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;
	localparam int WIDE_W = 64;

	typedef logic [DATA_WIDTH-1:0] entry_t;
	typedef logic [CMP_W-1:0]      cmp_t;

	typedef enum logic [FUNC_W-1:0] {
		FUNC_INSERT    = 2'd0,
		FUNC_REMOVE    = 2'd1,
		FUNC_OVERWRITE = 2'd2,
		FUNC_READ      = 2'd3
	} func_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK     = 2'd0,
		ST_EMPTY  = 2'd1,
		ST_BADPOS = 2'd2,
		ST_FULL   = 2'd3
	} status_t;

	typedef struct packed {
		logic [DOUT_W-1:0]  read_data;
		status_t            status;
		logic [COUNT_W-1:0] count;
	} ile_result_t;

endpackage

FILE: hdl/indexed_list_engine_unit.sv
// An accepted item waits in the input register; its answer loads into the result register as done rises.
// Throughput: one item per cycle; busy is low in every cycle after reset.
// The list update for an item lands at the same edge as its result register,
// so the next item already sees the new list.
// Reset (arst_n low) empties the list and holds busy high until the first clock edge.
// The receiver cannot stall: each result is valid for exactly one cycle.
module indexed_list_engine_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [ile_pkg::FUNC_W-1:0]    func,
	input  logic [ile_pkg::POS_W-1:0]     position,
	input  logic [ile_pkg::DIN_W-1:0]     data_in,
	output logic                          done,
	output logic [ile_pkg::DOUT_W-1:0]    read_data,
	output logic [ile_pkg::STATUS_W-1:0]  status,
	output logic [ile_pkg::COUNT_W-1:0]   count_out
);
	import ile_pkg::*;

	logic                busy_q;
	logic                valid_s1;
	func_t               func_s1;
	logic [POS_W-1:0]    position_s1;
	logic [DIN_W-1:0]    data_in_s1;
	ile_result_t         core_result;
	ile_result_t         result_q;
	logic                done_q;
	logic                accept;

	// Take an item whenever start is high and busy is low.
	assign accept = start && !busy_q;
	assign busy   = busy_q;

	// Hold busy high out of reset until the first clock edge, then drop it for good.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
		end else begin
			busy_q <= 1'b0;
		end
	end

	// Input register: item fields wait here while the list core works on them.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			func_s1     <= func_t'(func);
			position_s1 <= position;
			data_in_s1  <= data_in;
		end
	end

	// List storage, status decode and shift network.
	ile_list_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid    (valid_s1),
		.func     (func_s1),
		.position (position_s1),
		.data_in  (data_in_s1),
		.result   (core_result)
	);

	// Result register: capture the answer as the list updates; strobe done once.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			result_q <= core_result;
		end
	end

	assign done      = done_q;
	assign read_data = result_q.read_data;
	assign status    = result_q.status;
	assign count_out = result_q.count;

endmodule

FILE: hdl/ile_list_core.sv
module ile_list_core (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       valid,
	input  ile_pkg::func_t             func,
	input  logic [ile_pkg::POS_W-1:0]  position,
	input  logic [ile_pkg::DIN_W-1:0]  data_in,
	output ile_pkg::ile_result_t       result
);
	import ile_pkg::*;

	entry_t           entries_q [CAPACITY];
	entry_t           entries_d [CAPACITY];
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] count_d;

	cmp_t               pos_w;
	cmp_t               cnt_w;
	logic [WIDE_W-1:0]  din_wide;
	logic [WIDE_W-1:0]  rd_wide;
	entry_t             wr_val;
	status_t            status;
	logic               ins_ok;
	logic               rem_ok;
	logic               ovw_ok;
	logic               rd_ok;

	assign pos_w    = CMP_W'(position);
	assign cnt_w    = CMP_W'(count_q);
	assign din_wide = WIDE_W'(data_in);
	assign wr_val   = din_wide[DATA_WIDTH-1:0];
	assign rd_wide  = WIDE_W'(entries_q[pos_w[IDX_W-1:0]]);

	always_comb begin
		status = ST_OK;
		unique case (func)
			FUNC_INSERT: begin
				// position test ranks above the full test
				if (pos_w > cnt_w) begin
					status = ST_BADPOS;
				end else if (cnt_w >= CMP_W'(CAPACITY)) begin
					status = ST_FULL;
				end
			end
			FUNC_REMOVE, FUNC_OVERWRITE, FUNC_READ: begin
				if (cnt_w == '0) begin
					status = ST_EMPTY;
				end else if (pos_w >= cnt_w) begin
					status = ST_BADPOS;
				end
			end
			default: status = ST_OK;
		endcase
	end

	assign ins_ok = valid && (status == ST_OK) && (func == FUNC_INSERT);
	assign rem_ok = valid && (status == ST_OK) && (func == FUNC_REMOVE);
	assign ovw_ok = valid && (status == ST_OK) && (func == FUNC_OVERWRITE);
	assign rd_ok  = valid && (status == ST_OK) && (func == FUNC_READ);

	// Every entry picks its next value from itself, a neighbor or the write value in parallel.
	for (genvar g = 0; g < CAPACITY; g++) begin : g_entry
		entry_t from_below;
		entry_t from_above;
		if (g == 0) begin : g_first
			assign from_below = entries_q[0];
		end else begin : g_rest
			assign from_below = entries_q[g-1];
		end
		if (g == CAPACITY - 1) begin : g_last
			assign from_above = entries_q[g];
		end else begin : g_inner
			assign from_above = entries_q[g+1];
		end
		always_comb begin
			entries_d[g] = entries_q[g];
			if (ins_ok) begin
				if (CMP_W'(g) > pos_w) begin
					entries_d[g] = from_below;
				end else if (CMP_W'(g) == pos_w) begin
					entries_d[g] = wr_val;
				end
			end else if (rem_ok) begin
				if (CMP_W'(g) >= pos_w) begin
					entries_d[g] = from_above;
				end
			end else if (ovw_ok) begin
				if (CMP_W'(g) == pos_w) begin
					entries_d[g] = wr_val;
				end
			end
		end
	end

	always_comb begin
		count_d = count_q;
		if (ins_ok) begin
			count_d = count_q + CNT_W'(1);
		end else if (rem_ok) begin
			count_d = count_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		entries_q <= entries_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			count_q <= count_d;
		end
	end

	cmp_t cnt_next_w;
	assign cnt_next_w = CMP_W'(count_d);

	always_comb begin
		result.read_data = rd_ok ? rd_wide[DOUT_W-1:0] : '0;
		result.status    = status;
		result.count     = cnt_next_w[COUNT_W-1:0];
	end

endmodule

FILE: tb/tb.sv
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import ile_pkg::*;

	// Shadow copy of the list plus the queue of replies still owed by the block.
	class list_tracker;
		entry_t      shadow_list [CAPACITY];
		int          shadow_count;
		ile_result_t pending_replies [$];
		int          fail_count;

		function new();
			shadow_count = 0;
			fail_count   = 0;
		endfunction

		// Apply one accepted request to the shadow list and queue the reply it owes.
		function void note_request(func_t f, logic [POS_W-1:0] pos, logic [DIN_W-1:0] din);
			ile_result_t r;
			entry_t      val;
			int          p;
			r.read_data = '0;
			r.status    = ST_OK;
			val         = entry_t'(din);
			p           = int'(pos);
			if (f == FUNC_INSERT) begin
				// Position test comes before the full test.
				if (p > shadow_count)
					r.status = ST_BADPOS;
				else if (shadow_count >= CAPACITY)
					r.status = ST_FULL;
				else begin
					for (int k = shadow_count; k > p; k--)
						shadow_list[k] = shadow_list[k-1];
					shadow_list[p] = val;
					shadow_count++;
				end
			end else if (shadow_count == 0) begin
				r.status = ST_EMPTY;
			end else if (p >= shadow_count) begin
				r.status = ST_BADPOS;
			end else begin
				case (f)
					FUNC_REMOVE: begin
						for (int k = p; k + 1 < shadow_count; k++)
							shadow_list[k] = shadow_list[k+1];
						shadow_count--;
					end
					FUNC_OVERWRITE: begin
						shadow_list[p] = val;
					end
					default: begin
						r.read_data = DOUT_W'(shadow_list[p]);
					end
				endcase
			end
			r.count = COUNT_W'(shadow_count);
			pending_replies.push_back(r);
		endfunction

		function void check_reply(logic [DOUT_W-1:0] rd, logic [STATUS_W-1:0] st,
				logic [COUNT_W-1:0] cnt);
			ile_result_t e;
			if (pending_replies.size() == 0) begin
				fail_count++;
				if (fail_count <= 10)
					$display("ERROR %0t: reply with none pending: data=%h status=%0d count=%0d",
						$realtime, rd, st, cnt);
				return;
			end
			e = pending_replies.pop_front();
			if (rd !== e.read_data || st !== e.status || cnt !== e.count) begin
				fail_count++;
				if (fail_count <= 10)
					$display("ERROR %0t: exp data=%h status=%0d count=%0d, got data=%h status=%0d count=%0d",
						$realtime, e.read_data, e.status, e.count, rd, st, cnt);
			end
		endfunction

		function void close_out();
			if (pending_replies.size() != 0) begin
				fail_count += pending_replies.size();
				$display("ERROR: %0d replies never arrived", pending_replies.size());
			end
		endfunction
	endclass

	logic                clk = 1'b0;
	logic                arst_n;
	logic                start;
	logic                busy;
	logic [FUNC_W-1:0]   func;
	logic [POS_W-1:0]    position;
	logic [DIN_W-1:0]    data_in;
	logic                done;
	logic [DOUT_W-1:0]   read_data;
	logic [STATUS_W-1:0] status;
	logic [COUNT_W-1:0]  count_out;

	list_tracker tracker;
	bit          growing = 1'b1;

	indexed_list_engine_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.func      (func),
		.position  (position),
		.data_in   (data_in),
		.done      (done),
		.read_data (read_data),
		.status    (status),
		.count_out (count_out)
	);

	always #2 clk = ~clk;

	// Sample replies at the rising edge; the block strobes done for one cycle only.
	always @(posedge clk) begin
		if (arst_n === 1'b1 && done === 1'b1)
			tracker.check_reply(read_data, status, count_out);
	end

	// Present an item at the falling edge and hold it until an edge sees busy low.
	task automatic push_request(func_t f, logic [POS_W-1:0] pos, logic [DIN_W-1:0] din);
		@(negedge clk);
		start    <= 1'b1;
		func     <= f;
		position <= pos;
		data_in  <= din;
		do @(posedge clk); while (busy !== 1'b0);
		tracker.note_request(f, pos, din);
	endtask

	// Drop start for a random number of cycles, about 31 in a hundred overall.
	// Scramble the idle payload so the block must ignore it.
	task automatic hold_off(bit quiet);
		if (quiet)
			return;
		while ($urandom_range(0, 99) < 31) begin
			@(negedge clk);
			start    <= 1'b0;
			func     <= FUNC_W'($urandom);
			position <= POS_W'($urandom);
			data_in  <= $urandom;
		end
	endtask

	// Mix plain random words with the all-zero, all-one and one-hot extremes.
	function automatic logic [DIN_W-1:0] pick_data();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 70)
			return $urandom;
		else if (roll < 80)
			return '0;
		else if (roll < 90)
			return '1;
		return DIN_W'(1) << $urandom_range(0, DIN_W - 1);
	endfunction

	// Pick the next request kind and position from the current fill level. Alternate
	// between growing and shrinking runs so the list swings between empty and full.
	task automatic pick_request(output func_t f, output logic [POS_W-1:0] pos);
		int cnt;
		int roll;
		int sel;
		cnt = tracker.shadow_count;
		if (cnt == CAPACITY)
			growing = 1'b0;
		else if (cnt == 0)
			growing = 1'b1;
		else if ($urandom_range(0, 99) < 2)
			growing = !growing;
		roll = $urandom_range(0, 99);
		if (growing)
			f = (roll < 55) ? FUNC_INSERT : (roll < 70) ? FUNC_REMOVE :
				(roll < 85) ? FUNC_OVERWRITE : FUNC_READ;
		else
			f = (roll < 15) ? FUNC_INSERT : (roll < 55) ? FUNC_REMOVE :
				(roll < 78) ? FUNC_OVERWRITE : FUNC_READ;
		sel = $urandom_range(0, 99);
		if (sel < 85) begin
			// Well-formed position for this kind of request.
			if (f == FUNC_INSERT)
				pos = POS_W'($urandom_range(0, cnt));
			else
				pos = (cnt == 0) ? '0 : POS_W'($urandom_range(0, cnt - 1));
		end else if (sel < 95) begin
			pos = POS_W'($urandom_range(0, (1 << POS_W) - 1));
		end else begin
			// Just at or past the end.
			pos = POS_W'(cnt + $urandom_range(0, 1));
		end
	endtask

	initial begin
		func_t            f;
		logic [POS_W-1:0] pos;
		bit               quiet;
		tracker  = new();
		arst_n   = 1'b0;
		start    = 1'b0;
		func     = FUNC_INSERT;
		position = '0;
		data_in  = '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed: empty list, bad positions, front/middle/end inserts, overwrite,
		// removes at middle and end, then fill to capacity and poke the full list.
		push_request(FUNC_READ, 5'd0, 32'h0);
		push_request(FUNC_REMOVE, 5'd0, 32'h0);
		push_request(FUNC_OVERWRITE, 5'd31, 32'hDEADBEEF);
		push_request(FUNC_INSERT, 5'd1, 32'h12345678);
		push_request(FUNC_INSERT, 5'd0, 32'hFFFFFFFF);
		push_request(FUNC_INSERT, 5'd0, 32'h00000000);
		push_request(FUNC_INSERT, 5'd2, 32'hA5A5A5A5);
		push_request(FUNC_INSERT, 5'd1, 32'h5A5A5A5A);
		push_request(FUNC_READ, 5'd31, 32'h0);
		push_request(FUNC_OVERWRITE, 5'd3, 32'h80000001);
		push_request(FUNC_READ, 5'd3, 32'h0);
		push_request(FUNC_REMOVE, 5'd1, 32'h0);
		push_request(FUNC_REMOVE, 5'd2, 32'h0);
		while (tracker.shadow_count < CAPACITY)
			push_request(FUNC_INSERT, POS_W'(tracker.shadow_count), $urandom);
		push_request(FUNC_INSERT, 5'd3, 32'hCAFEF00D);
		push_request(FUNC_INSERT, POS_W'(CAPACITY + 1), 32'h0);
		push_request(FUNC_READ, POS_W'(CAPACITY - 1), 32'h0);
		push_request(FUNC_REMOVE, 5'd0, 32'h0);

		// Random: hold start high back to back through one long stretch in the middle.
		for (int n = 0; n < 800; n++) begin
			quiet = (n >= 300 && n < 450);
			hold_off(quiet);
			pick_request(f, pos);
			push_request(f, pos, pick_data());
		end

		@(negedge clk);
		start <= 1'b0;

		// Drain: wait for the owed replies, then a few cycles for strays.
		for (int w = 0; w < 1000 && tracker.pending_replies.size() != 0; w++)
			@(posedge clk);
		repeat (8) @(posedge clk);
		tracker.close_out();
		if (tracker.fail_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	// Watchdog: a correct run ends far earlier.
	initial begin
		#2000000;
		$display("Verification failed");
		$finish;
	end

endmodule

FILE: files.f
hdl/ile_pkg.sv
hdl/ile_list_core.sv
hdl/indexed_list_engine_unit.sv
tb/tb.sv
